>>> rtl/multi_timer_tick_expiry_unit_assert.svh
// Assertion macros for the timer table; the enclosing module supplies clk and arst_n.
`ifndef MULTI_TIMER_TICK_EXPIRY_UNIT_ASSERT_SVH
`define MULTI_TIMER_TICK_EXPIRY_UNIT_ASSERT_SVH

// Same-cycle implication.
`define MTTE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MTTE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/mtte_pkg.sv
`timescale 1ns / 1ps

package mtte_pkg;

	localparam int TIMERS_DEF = 16;
	localparam logic [4:0] TS_NONE = 5'd16;
	localparam logic [31:0] DEADLINE_NONE = 32'hFFFF_FFFF;

	typedef enum logic [0:0] {
		OP_TICK = 1'b0,
		OP_ARM  = 1'b1
	} mtte_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_EVAL,
		ST_FLUSH
	} mtte_state_t;

	typedef struct packed {
		logic        operation;
		logic [3:0]  timer_index;
		logic [31:0] deadline;
		logic [31:0] payload;
	} mtte_in_t;

	typedef struct packed {
		logic [3:0]  expired_index;
		logic [31:0] expired_payload;
		logic        task_switch;
		logic        last_result;
	} mtte_out_t;

endpackage

>>> rtl/mtte_out_stage.sv
`timescale 1ns / 1ps

module mtte_out_stage
	import mtte_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  mtte_out_t push_item,
	output logic      free,
	output logic      out_valid,
	input  logic      out_ready,
	output mtte_out_t out_data
);

	logic      valid_q;
	mtte_out_t data_q;

	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= push_item;
		end
	end

endmodule

>>> rtl/multi_timer_tick_expiry_unit.sv
`timescale 1ns / 1ps

// Table of TIMERS one-shot timers with absolute deadlines against a wrapping 32-bit
// tick count. A tick transfer goes from idle to a check state and back to idle when
// the earliest deadline is still ahead. Otherwise the table is scanned one entry at a
// time through the single read port of the deadline/payload memory, with a read state
// and an evaluate state per entry, and then flushed. An evaluate step may wait on the
// result side, as may the flush, which sends a task-switch result after any pending
// payload result. Results leave through an output register in index order. The
// task-switch result comes after the scan, and last_result is set on the final one. The
// block takes no new item until scan and flush are done. No clearing pass after reset.
`include "multi_timer_tick_expiry_unit_assert.svh"

module multi_timer_tick_expiry_unit
	import mtte_pkg::*;
#(
	parameter int TIMERS = TIMERS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  mtte_in_t   in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output mtte_out_t  out_data,
	input  logic       cfg_wen,
	input  logic [4:0] cfg_wdata
);

	localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(TIMERS - 1);

	mtte_state_t state_q, state_d;
	logic [31:0] tick_q;
	logic [31:0] earliest_q;
	logic [TIMERS-1:0] armed_q;
	logic [4:0] tst_q;
	logic [IW-1:0] idx_q;
	logic ts_hit_q;
	logic held_valid_q;
	mtte_out_t held_q;

	logic [31:0] dl_mem [TIMERS];
	logic [31:0] pay_mem [TIMERS];
	logic [31:0] dl_rd_q;
	logic [31:0] pay_rd_q;

	logic accept, tick_go, arm_ok;
	logic hit, is_ts, stall;
	logic out_free;
	logic push;
	mtte_out_t push_item;
	mtte_out_t new_item;
	logic rd_en, idx_clr, idx_inc, disarm, ear_reset, ear_load;
	logic held_load, held_clr, ts_set, ts_clr;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign tick_go  = accept && (in_data.operation == OP_TICK);
	assign arm_ok   = accept && (in_data.operation == OP_ARM)
		&& (32'(in_data.timer_index) < 32'(TIMERS));

	assign hit   = armed_q[idx_q] && (tick_q >= dl_rd_q);
	assign is_ts = (8'(idx_q) == 8'(tst_q));

	always_comb begin
		new_item.expired_index   = 4'(idx_q);
		new_item.expired_payload = pay_rd_q;
		new_item.task_switch     = 1'b0;
		new_item.last_result     = 1'b0;
	end

	always_comb begin
		state_d   = state_q;
		push      = 1'b0;
		push_item = held_q;
		rd_en     = 1'b0;
		idx_clr   = 1'b0;
		idx_inc   = 1'b0;
		disarm    = 1'b0;
		ear_reset = 1'b0;
		ear_load  = 1'b0;
		held_load = 1'b0;
		held_clr  = 1'b0;
		ts_set    = 1'b0;
		ts_clr    = 1'b0;
		stall     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (tick_go) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (earliest_q > tick_q) begin
					state_d = ST_IDLE;
				end else begin
					ear_reset = 1'b1;
					idx_clr   = 1'b1;
					state_d   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				rd_en   = 1'b1;
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				// a second payload result can only go once the pending one has left
				stall = hit && !is_ts && held_valid_q && !out_free;
				if (!stall) begin
					if (hit) begin
						disarm = 1'b1;
						if (is_ts) begin
							ts_set = 1'b1;
						end else begin
							push      = held_valid_q;
							held_load = 1'b1;
						end
					end else if (armed_q[idx_q] && (dl_rd_q < earliest_q)) begin
						ear_load = 1'b1;
					end
					if (idx_q == LAST_IDX) begin
						state_d = ST_FLUSH;
					end else begin
						idx_inc = 1'b1;
						state_d = ST_SCAN;
					end
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					if (held_valid_q) begin
						push                  = 1'b1;
						push_item.last_result = !ts_hit_q;
						held_clr              = 1'b1;
						if (!ts_hit_q) begin
							state_d = ST_IDLE;
						end
					end else if (ts_hit_q) begin
						push                      = 1'b1;
						push_item.expired_index   = tst_q[3:0];
						push_item.expired_payload = '0;
						push_item.task_switch     = 1'b1;
						push_item.last_result     = 1'b1;
						ts_clr                    = 1'b1;
						state_d                   = ST_IDLE;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			tick_q       <= '0;
			earliest_q   <= DEADLINE_NONE;
			armed_q      <= '0;
			tst_q        <= TS_NONE;
			idx_q        <= '0;
			ts_hit_q     <= 1'b0;
			held_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wen) begin
				tst_q <= cfg_wdata;
			end
			if (tick_go) begin
				tick_q <= tick_q + 32'd1;
			end
			if (arm_ok) begin
				armed_q[IW'(in_data.timer_index)] <= 1'b1;
				if (in_data.deadline < earliest_q) begin
					earliest_q <= in_data.deadline;
				end
			end else if (ear_reset) begin
				earliest_q <= DEADLINE_NONE;
			end else if (ear_load) begin
				earliest_q <= dl_rd_q;
			end
			if (disarm) begin
				armed_q[idx_q] <= 1'b0;
			end
			if (idx_clr) begin
				idx_q <= '0;
			end else if (idx_inc) begin
				idx_q <= idx_q + IW'(1);
			end
			if (ts_set) begin
				ts_hit_q <= 1'b1;
			end else if (ts_clr) begin
				ts_hit_q <= 1'b0;
			end
			if (held_load) begin
				held_valid_q <= 1'b1;
			end else if (held_clr) begin
				held_valid_q <= 1'b0;
			end
		end
	end

	// hold the newest expired entry until the next one shows whether it is the last
	always_ff @(posedge clk) begin
		if (held_load) begin
			held_q <= new_item;
		end
	end

	always_ff @(posedge clk) begin
		if (arm_ok) begin
			dl_mem[IW'(in_data.timer_index)]  <= in_data.deadline;
			pay_mem[IW'(in_data.timer_index)] <= in_data.payload;
		end
		if (rd_en) begin
			dl_rd_q  <= dl_mem[idx_q];
			pay_rd_q <= pay_mem[idx_q];
		end
	end

	mtte_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.free      (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	`MTTE_ASSERT_NOW(a_idle_clean, state_q == ST_IDLE, !held_valid_q && !ts_hit_q,
		"pending result left over outside a scan")
	`MTTE_ASSERT_NEXT(a_earliest_only_lowers, state_q != ST_CHECK,
		earliest_q <= $past(earliest_q), "earliest deadline rose outside the tick check")
	`MTTE_ASSERT_NEXT(a_tick_advance, tick_go,
		(tick_q == $past(tick_q) + 32'd1) && (state_q == ST_CHECK),
		"tick transfer did not advance the count")
	`MTTE_ASSERT_NOW(a_push_free, push, out_free, "result pushed into a full output register")

endmodule
